/* hw/rtl/slsld_pkg.sv */
package slsld_pkg;

  localparam int unsigned LampColumns = 8;
  localparam int unsigned SolWidth    = 18;
  localparam int unsigned LampWidth   = 8 * LampColumns;
  localparam int unsigned CmdWidth    = 8;

  localparam logic [3:0] OffSolHigh  = 4'd0;
  localparam logic [3:0] OffSolLow   = 4'd1;
  localparam logic [3:0] OffSoundLo  = 4'd2;
  localparam logic [3:0] OffSoundHi  = 4'd3;

  localparam int unsigned MuxBit = 16;

  localparam logic [1:0] RegSoundMask = 2'd0;

  typedef struct packed {
    logic [3:0] latch_offset;
    logic [7:0] write_byte;
  } slsld_item_t;

endpackage

/* hw/rtl/solenoid_lamp_sound_latch_decoder_top.sv */
// An accepted input item is held in the input register, then passes through the update
// into the state/result register, which presents the result item.
// Throughput: one item per cycle while out_tready does not stall the output, set by the
// single update pass between the input register and the state/result register.
// Reset: synchronous, active low; solenoids, lamps, sound command, last sent
// command and the sound mask register clear to zero and both stages empty.
module solenoid_lamp_sound_latch_decoder_top
  import slsld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] write_byte
  input  logic [3:0]  in_tuser,   // [3:0] latch_offset
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [17:0] solenoid_word, [81:18] lamp_columns,
                                  // [89:82] sound_command, [95:90] zero
  output logic        out_tuser,  // [0] sound_send
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                 advance;
  logic                 item_valid;
  slsld_item_t          in_item;
  slsld_item_t          item;
  logic [7:0]           sound_mask;
  logic [SolWidth-1:0]  solenoid_word;
  logic [LampWidth-1:0] lamp_columns;
  logic [CmdWidth-1:0]  sound_command;

  assign in_item.latch_offset = in_tuser;
  assign in_item.write_byte   = in_tdata;

  slsld_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .sound_mask  (sound_mask)
  );

  slsld_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  slsld_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .sound_mask    (sound_mask),
    .advance       (advance),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .solenoid_word (solenoid_word),
    .lamp_columns  (lamp_columns),
    .sound_command (sound_command),
    .sound_send    (out_tuser)
  );

  assign out_tdata = {6'd0, sound_command, lamp_columns, solenoid_word};

endmodule

/* hw/rtl/slsld_cfg.sv */
module slsld_cfg
  import slsld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [7:0]  sound_mask
);

  logic [7:0] mask_r;
  logic [7:0] mask_nxt;
  logic       sel_mask;

  assign cfg_pready = 1'b1;
  assign sel_mask   = (cfg_paddr[3:2] == RegSoundMask);

  always_comb begin
    mask_nxt = mask_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_mask) begin
      mask_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  assign cfg_prdata = sel_mask ? {24'd0, mask_r} : 32'd0;
  assign sound_mask = mask_r;

endmodule

/* hw/rtl/slsld_in_stage.sv */
module slsld_in_stage
  import slsld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  slsld_item_t in_item,
  input  logic        advance,
  output logic        item_valid,
  output slsld_item_t item
);

  logic        valid_r;
  logic        valid_nxt;
  slsld_item_t item_r;
  slsld_item_t item_nxt;
  logic        take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    if (take) begin
      item_nxt = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* hw/rtl/slsld_core.sv */
module slsld_core
  import slsld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  slsld_item_t          item,
  input  logic [7:0]           sound_mask,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SolWidth-1:0]  solenoid_word,
  output logic [LampWidth-1:0] lamp_columns,
  output logic [CmdWidth-1:0]  sound_command,
  output logic                 sound_send
);

  logic [SolWidth-1:0] sol_r;
  logic [SolWidth-1:0] sol_nxt;
  logic [7:0]          lamp_r [LampColumns];
  logic [7:0]          lamp_nxt [LampColumns];
  logic [CmdWidth-1:0] cmd_r;
  logic [CmdWidth-1:0] cmd_nxt;
  logic [CmdWidth-1:0] last_r;
  logic [CmdWidth-1:0] last_nxt;
  logic                send_r;
  logic                send_nxt;
  logic                valid_r;
  logic                valid_nxt;
  logic                load;
  logic [3:0]          hi_nib;
  logic [3:0]          lo_nib;
  logic [2:0]          col;

  assign advance = !valid_r || out_ready;
  assign load    = advance && item_valid;
  assign hi_nib  = item.write_byte[7:4];
  assign lo_nib  = item.write_byte[3:0];

  always_comb begin
    sol_nxt  = sol_r;
    cmd_nxt  = cmd_r;
    last_nxt = last_r;
    send_nxt = 1'b0;
    case (item.latch_offset)
      OffSolHigh: begin
        sol_nxt[17:16] = hi_nib[3:2];
        if (hi_nib[2]) begin
          sol_nxt[11:10] = hi_nib[1:0];
        end else begin
          sol_nxt[5:4] = hi_nib[1:0];
        end
      end
      OffSolLow: begin
        if (sol_r[MuxBit]) begin
          sol_nxt[9:6] = hi_nib;
        end else begin
          sol_nxt[3:0] = hi_nib;
        end
      end
      OffSoundLo: begin
        cmd_nxt[3:0] = hi_nib & ~sound_mask[3:0];
        if (cmd_nxt != last_r) begin
          last_nxt = cmd_nxt;
          send_nxt = 1'b1;
        end
      end
      OffSoundHi: begin
        cmd_nxt[7:4]   = hi_nib & ~sound_mask[7:4];
        sol_nxt[13:12] = hi_nib[3:2];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    col = '0;
    for (int c = 0; c < LampColumns; c++) begin
      lamp_nxt[c] = lamp_r[c];
    end
    for (int k = 0; k < 4; k++) begin
      col = {item.latch_offset[3], 2'(k)};
      lamp_nxt[col][item.latch_offset[2:0]] = lo_nib[2'(3 - k)];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sol_r   <= '0;
      cmd_r   <= '0;
      last_r  <= '0;
      send_r  <= 1'b0;
      for (int c = 0; c < LampColumns; c++) begin
        lamp_r[c] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        sol_r  <= sol_nxt;
        cmd_r  <= cmd_nxt;
        last_r <= last_nxt;
        send_r <= send_nxt;
        for (int c = 0; c < LampColumns; c++) begin
          lamp_r[c] <= lamp_nxt[c];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < LampColumns; c++) begin
      lamp_columns[8*c +: 8] = lamp_r[c];
    end
  end

  assign out_valid     = valid_r;
  assign solenoid_word = sol_r;
  assign sound_command = cmd_r;
  assign sound_send    = send_r;

`ifndef ASSERT_OFF
  a_send_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
    send_r |-> (last_r == cmd_r))
    else $error("sent command differs from the command shown");

  a_send_only_offset2: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (item.latch_offset != OffSoundLo)) |=> !send_r)
    else $error("send strobe raised by a write to another offset");

  a_sol_kept_high_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (item.latch_offset[3:2] != 2'b00)) |=> $stable(sol_r))
    else $error("solenoid word changed by a lamp-only offset");

  a_lamp_upper_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !item.latch_offset[3]) |=> $stable(lamp_columns[LampWidth-1:LampWidth/2]))
    else $error("upper lamp columns changed by a low offset");
`endif

endmodule

/* verif/solenoid_lamp_sound_latch_decoder_top_tb.sv */
`timescale 1ns / 100ps

module solenoid_lamp_sound_latch_decoder_top_tb;
  import slsld_pkg::*;

  localparam logic [1:0] RegUnused = 2'd1;

  typedef struct packed {
    logic [SolWidth-1:0]  solenoids;
    logic [LampWidth-1:0] lamps;
    logic [CmdWidth-1:0]  command;
    logic                 send;
  } decoded_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic [3:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  solenoid_lamp_sound_latch_decoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow copy of the decoder state.
  logic [SolWidth-1:0] sol_bits = '0;
  logic [7:0]          lamp_rows [LampColumns];
  logic [CmdWidth-1:0] cmd_now  = '0;
  logic [CmdWidth-1:0] cmd_sent = '0;
  logic [7:0]          sound_mask = '0;

  slsld_item_t latch_writes_q [$];
  decoded_t    decoded_q [$];
  slsld_item_t on_bus;
  bit          item_taken = 1'b0;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned mismatches = 0;
  logic [7:0]  chunk_masks [6];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2000000;
    $display("solenoid_lamp_sound_latch_decoder_top_tb failed");
    $finish;
  end

  function automatic void flag_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endfunction

  function automatic void decode_latch_write(input slsld_item_t wr);
    logic [7:0]  d;
    logic [7:0]  keep;
    logic [2:0]  row;
    int unsigned base;
    decoded_t    res;
    d    = wr.write_byte;
    keep = ~sound_mask;
    res  = '0;
    case (wr.latch_offset)
      OffSolHigh: begin
        sol_bits[17:16] = d[7:6];
        if (sol_bits[MuxBit]) begin
          sol_bits[11:10] = d[5:4];
        end else begin
          sol_bits[5:4] = d[5:4];
        end
      end
      OffSolLow: begin
        if (sol_bits[MuxBit]) begin
          sol_bits[9:6] = d[7:4];
        end else begin
          sol_bits[3:0] = d[7:4];
        end
      end
      OffSoundLo: begin
        cmd_now[3:0] = d[7:4] & keep[3:0];
        if (cmd_now != cmd_sent) begin
          cmd_sent = cmd_now;
          res.send = 1'b1;
        end
      end
      OffSoundHi: begin
        cmd_now[7:4]    = d[7:4] & keep[7:4];
        sol_bits[13:12] = d[7:6];
      end
      default: ;
    endcase
    row  = wr.latch_offset[2:0];
    base = wr.latch_offset[3] ? 4 : 0;
    for (int k = 0; k < 4; k++) begin
      lamp_rows[base + k][row] = d[3 - k];
    end
    for (int k = 0; k < LampColumns; k++) begin
      res.lamps[8*k +: 8] = lamp_rows[k];
    end
    res.solenoids = sol_bits;
    res.command   = cmd_now;
    decoded_q.push_back(res);
  endfunction

  initial begin
    for (int k = 0; k < LampColumns; k++) begin
      lamp_rows[k] = '0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {RegSoundMask, 2'b00}) begin
        sound_mask = cfg_pwdata[7:0];
      end
      if (in_tvalid && in_tready) begin
        decode_latch_write(on_bus);
        items_accepted++;
        item_taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || item_taken) begin
        if (latch_writes_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          on_bus = latch_writes_q.pop_front();
          in_tdata  <= on_bus.write_byte;
          in_tuser  <= on_bus.latch_offset;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      item_taken = 1'b0;
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch("unexpected item", '0, out_tdata[63:0]);
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata[17:0] !== want.solenoids) begin
          flag_mismatch("solenoid_word", 64'(want.solenoids), 64'(out_tdata[17:0]));
        end
        if (out_tdata[81:18] !== want.lamps) begin
          flag_mismatch("lamp_columns", want.lamps, out_tdata[81:18]);
        end
        if (out_tdata[89:82] !== want.command) begin
          flag_mismatch("sound_command", 64'(want.command), 64'(out_tdata[89:82]));
        end
        if (out_tuser !== want.send) begin
          flag_mismatch("sound_send", 64'(want.send), 64'(out_tuser));
        end
      end
    end
  end

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic write_sound_mask(input logic [7:0] value);
    apb_write({RegSoundMask, 2'b00}, {24'h0, value});
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {RegSoundMask, 2'b00};
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {24'h0, sound_mask}) begin
      flag_mismatch("sound mask readback", 64'({24'h0, sound_mask}), 64'(cfg_prdata));
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic queue_latch_write(input logic [3:0] offset, input logic [7:0] data);
    slsld_item_t wr;
    wr.latch_offset = offset;
    wr.write_byte   = data;
    latch_writes_q.push_back(wr);
    items_queued++;
  endtask

  task automatic queue_random_writes(input int unsigned count);
    logic [3:0] offset;
    @(posedge clk);
    repeat (count) begin
      offset = ($urandom_range(9) < 6) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
      queue_latch_write(offset, 8'($urandom_range(255)));
    end
  endtask

  task automatic drain_results();
    do begin
      @(negedge clk);
    end while (latch_writes_q.size() != 0 || items_accepted != items_queued ||
               decoded_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_sound_mask(8'h00);
    @(posedge clk);
    sender_idle_pct   = 19;
    receiver_idle_pct = 52;
    queue_latch_write(OffSoundLo, 8'h00);
    queue_latch_write(OffSolHigh, 8'hff);
    queue_latch_write(OffSolLow, 8'hff);
    queue_latch_write(OffSoundHi, 8'hff);
    queue_latch_write(OffSoundLo, 8'h5a);
    queue_latch_write(OffSoundLo, 8'h5f);
    queue_latch_write(OffSolHigh, 8'h30);
    queue_latch_write(OffSolLow, 8'ha0);
    queue_latch_write(OffSolHigh, 8'h00);
    for (int off = 4; off < 16; off++) begin
      queue_latch_write(4'(off), off[0] ? 8'hff : 8'h0a);
    end
    drain_results();

    // The write to the unused register must leave the mask alone.
    write_sound_mask(8'hff);
    apb_write({RegUnused, 2'b00}, 32'h0);
    write_sound_mask(8'hff);
    @(posedge clk);
    queue_latch_write(OffSoundLo, 8'hf0);
    queue_latch_write(OffSoundHi, 8'hff);
    queue_latch_write(OffSoundLo, 8'hff);
    drain_results();

    chunk_masks = '{8'h0f, 8'hf0, 8'($urandom_range(255)), 8'h00,
                    8'($urandom_range(255)), 8'hff};
    for (int c = 0; c < 6; c++) begin
      write_sound_mask(chunk_masks[c]);
      @(posedge clk);
      case (c / 2)
        0: begin
          sender_idle_pct   = 19;
          receiver_idle_pct = 52;
        end
        1: begin
          sender_idle_pct   = 52;
          receiver_idle_pct = 19;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      if (c == 1) begin
        queue_random_writes(111);
        drain_results();
        queue_random_writes(111);
      end else begin
        queue_random_writes(222);
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("solenoid_lamp_sound_latch_decoder_top_tb passed");
    end else begin
      $display("solenoid_lamp_sound_latch_decoder_top_tb failed");
    end
    $finish;
  end

endmodule
